### hw/rtl/json_string_escaper_defines.svh
// Assertion macros for the escaper RTL.
// Every check samples on clk_i and is held off while rst_ni is low.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

// Property checked at every clock edge out of reset.
`define JSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("json_string_escaper assertion failed");

// Implication: consequent checked in the cycle after the antecedent.
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json_string_escaper assertion failed");

`endif

### hw/rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, codes and helpers shared by the JSON string escaper modules.
// ----------------------------------------------------------------------------
package jse_pkg;

  // Input action codes
  localparam logic [1:0] ACT_OPEN  = 2'd0;
  localparam logic [1:0] ACT_CHAR  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // ASCII bytes used in escapes
  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_BSL   = 7'h5C;
  localparam logic [6:0] CH_SLASH = 7'h2F;
  localparam logic [6:0] CH_U     = 7'h75;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_B     = 7'h62;
  localparam logic [6:0] CH_F     = 7'h66;
  localparam logic [6:0] CH_N     = 7'h6E;
  localparam logic [6:0] CH_R     = 7'h72;
  localparam logic [6:0] CH_T     = 7'h74;
  localparam logic [6:0] CH_UPPER_A = 7'h41;

  // Control bytes with a short escape
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  // Printable range limits
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'd126;

  // Queue depth and byte index width (six bytes at most per item)
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned IdxW   = 3;

  // How an item expands
  typedef enum logic [1:0] {
    KIND_ONE = 2'd0,  // one byte, the data itself
    KIND_TWO = 2'd1,  // backslash, then the data
    KIND_UNI = 2'd2   // backslash u 0 0 and two hex digits of the data
  } kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Upper-case hex digit of a nibble
  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] res;
    if (nib < 4'd10) begin
      res = CH_ZERO + {3'd0, nib};
    end else begin
      res = CH_UPPER_A + {3'd0, nib} - 7'd10;
    end
    return res;
  endfunction

  // Index of the final byte of an expansion
  function automatic logic [IdxW-1:0] last_idx(input kind_e kind);
    logic [IdxW-1:0] res;
    case (kind)
      KIND_ONE: res = IdxW'(0);
      KIND_TWO: res = IdxW'(1);
      KIND_UNI: res = IdxW'(5);
      default:  res = IdxW'(0);
    endcase
    return res;
  endfunction

endpackage

### hw/rtl/json_string_escaper.sv
// An accepted item is written into the command queue; its first output byte then goes to the output register.
// Throughput: one output byte per cycle while out_ready_i is high and a command
//   is queued; an item expands to 1, 2 or 6 bytes through the single output register.
// Input accepts every cycle while the two-entry command queue is not full.
// Reset (rst_ni, async active low) empties the queue and output register.
// ----------------------------------------------------------------------------
// json_string_escaper
// Escapes a byte stream into a JSON quoted string, one byte per result.
// ----------------------------------------------------------------------------
`include "json_string_escaper_defines.svh"

module json_string_escaper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jse_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jse_pkg::out_item_t  out_item_o
);
  import jse_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  // Front: classify items
  jse_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .q_full_i   (q_status.full)
  );

  // Queue between the two halves
  jse_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Back: emit escaped bytes
  jse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!q_status.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // Checks
  `JSE_ASSERT(a_no_push_full, !(push && q_status.full))
  `JSE_ASSERT(a_no_pop_empty, !(pop && q_status.empty))
  `JSE_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_o && out_item_o.run_last)

endmodule

### hw/rtl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Classifies an input item into an expansion command for the back end.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jse_pkg::in_item_t in_item_i,
  output logic              push_o,
  output jse_pkg::cmd_t     cmd_o,
  input  logic              q_full_i
);
  import jse_pkg::*;

  logic has_cmd;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o && has_cmd;

  // Decode action and byte class
  always_comb begin
    has_cmd   = 1'b1;
    cmd_o.kind = KIND_ONE;
    cmd_o.data = in_item_i.char_in;
    case (in_item_i.action)
      ACT_OPEN, ACT_CLOSE: begin
        cmd_o.kind = KIND_ONE;
        cmd_o.data = {1'b0, CH_QUOTE};
      end
      ACT_CHAR: begin
        case (in_item_i.char_in)
          {1'b0, CH_QUOTE}, {1'b0, CH_BSL}, {1'b0, CH_SLASH}: begin
            cmd_o.kind = KIND_TWO;
          end
          CTL_BS: begin
            cmd_o.kind = KIND_TWO;
            cmd_o.data = {1'b0, CH_B};
          end
          CTL_FF: begin
            cmd_o.kind = KIND_TWO;
            cmd_o.data = {1'b0, CH_F};
          end
          CTL_LF: begin
            cmd_o.kind = KIND_TWO;
            cmd_o.data = {1'b0, CH_N};
          end
          CTL_CR: begin
            cmd_o.kind = KIND_TWO;
            cmd_o.data = {1'b0, CH_R};
          end
          CTL_HT: begin
            cmd_o.kind = KIND_TWO;
            cmd_o.data = {1'b0, CH_T};
          end
          default: begin
            if (in_item_i.char_in < PRINT_LO || in_item_i.char_in > PRINT_HI) begin
              cmd_o.kind = KIND_UNI;
            end else begin
              cmd_o.kind = KIND_ONE;
            end
          end
        endcase
      end
      // unused action: accepted, produces nothing
      default: begin
        has_cmd = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/jse_cmd_queue.sv
// ----------------------------------------------------------------------------
// jse_cmd_queue
// Small FIFO of expansion commands between front and back end.
// ----------------------------------------------------------------------------
module jse_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jse_pkg::cmd_t       push_cmd_i,
  input  logic                pop_i,
  output jse_pkg::cmd_t       head_o,
  output jse_pkg::q_status_t  status_o
);
  import jse_pkg::*;

  cmd_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    count_q, count_d;

  assign status_o.full  = (count_q == (QPtrW+1)'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### hw/rtl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands the head command byte by byte into the output register.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jse_pkg::cmd_t       head_i,
  input  logic                head_valid_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jse_pkg::out_item_t  out_item_o
);
  import jse_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            load;
  logic            is_last;
  logic [6:0]      cur_byte;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == last_idx(head_i.kind));
  assign pop_o   = load && is_last;

  // Byte at the current index of the expansion
  always_comb begin
    cur_byte = head_i.data[6:0];
    case (head_i.kind)
      KIND_ONE: cur_byte = head_i.data[6:0];
      KIND_TWO: cur_byte = (idx_q == '0) ? CH_BSL : head_i.data[6:0];
      KIND_UNI: begin
        case (idx_q)
          IdxW'(0): cur_byte = CH_BSL;
          IdxW'(1): cur_byte = CH_U;
          IdxW'(2): cur_byte = CH_ZERO;
          IdxW'(3): cur_byte = CH_ZERO;
          IdxW'(4): cur_byte = hex_digit(head_i.data[7:4]);
          default:  cur_byte = hex_digit(head_i.data[3:0]);
        endcase
      end
      default: cur_byte = head_i.data[6:0];
    endcase
  end

  // Index and output register next values
  always_comb begin
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      idx_d          = is_last ? '0 : idx_q + 1'b1;
      out_d.char_out = cur_byte;
      out_d.run_last = is_last;
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for json_string_escaper. String framing, every escape
// class and random well-formed strings with noise are sent under changing
// idle patterns on both sides. Each input item is expanded here into the
// bytes it should produce, and every output item is compared in order.
// ----------------------------------------------------------------------------
module testbench;
  import jse_pkg::*;

  // Action code the block ignores
  localparam logic [1:0] ACT_SPARE    = 2'd3;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         PHASE_ITEMS  = 160;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;

  // Escaped bytes still owed by the block, oldest first
  out_item_t escaped_bytes_q[$];

  json_string_escaper i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Expand one accepted item into the escaped bytes it must produce
  function automatic void predict_escape(input in_item_t it);
    logic [6:0] seq [6];
    logic [7:0] c;
    int         n;
    c = it.char_in;
    n = 0;
    case (it.action)
      ACT_OPEN, ACT_CLOSE: begin
        seq[0] = CH_QUOTE;
        n = 1;
      end
      ACT_CHAR: begin
        case (c)
          {1'b0, CH_QUOTE}, {1'b0, CH_BSL}, {1'b0, CH_SLASH}: begin
            seq[0] = CH_BSL;
            seq[1] = c[6:0];
            n = 2;
          end
          CTL_BS: begin seq[0] = CH_BSL; seq[1] = CH_B; n = 2; end
          CTL_FF: begin seq[0] = CH_BSL; seq[1] = CH_F; n = 2; end
          CTL_LF: begin seq[0] = CH_BSL; seq[1] = CH_N; n = 2; end
          CTL_CR: begin seq[0] = CH_BSL; seq[1] = CH_R; n = 2; end
          CTL_HT: begin seq[0] = CH_BSL; seq[1] = CH_T; n = 2; end
          default: begin
            if (c < PRINT_LO || c > PRINT_HI) begin
              // \u00XX with upper-case hex digits
              seq[0] = CH_BSL;
              seq[1] = CH_U;
              seq[2] = CH_ZERO;
              seq[3] = CH_ZERO;
              seq[4] = (c[7:4] < 4'd10) ? CH_ZERO + 7'(c[7:4])
                                        : CH_UPPER_A + 7'(c[7:4]) - 7'd10;
              seq[5] = (c[3:0] < 4'd10) ? CH_ZERO + 7'(c[3:0])
                                        : CH_UPPER_A + 7'(c[3:0]) - 7'd10;
              n = 6;
            end else begin
              seq[0] = c[6:0];
              n = 1;
            end
          end
        endcase
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      escaped_bytes_q.push_back('{char_out: seq[k], run_last: (k == n - 1)});
    end
  endfunction

  // Send one item; returns at the edge where it is accepted
  task automatic send_action(input logic [1:0] act, input logic [7:0] ch);
    in_item_t it;
    it.action  = act;
    it.char_in = ch;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_escape(it);
  endtask

  // Byte mix weighted toward the escape classes
  function automatic logic [7:0] pick_char();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(99);
    if (r < 45) begin
      c = 8'($urandom_range(126, 32));
    end else if (r < 70) begin
      case ($urandom_range(7))
        0: c = {1'b0, CH_QUOTE};
        1: c = {1'b0, CH_BSL};
        2: c = {1'b0, CH_SLASH};
        3: c = CTL_BS;
        4: c = CTL_FF;
        5: c = CTL_LF;
        6: c = CTL_CR;
        default: c = CTL_HT;
      endcase
    end else begin
      c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  // Open and close with stray bytes, and the ignored action
  task automatic test_string_framing();
    send_action(ACT_OPEN, 8'hFF);
    send_action(ACT_CLOSE, 8'h00);
    send_action(ACT_OPEN, 8'h00);
    send_action(ACT_SPARE, {1'b0, CH_QUOTE});
    send_action(ACT_SPARE, 8'hFF);
    send_action(ACT_CLOSE, 8'hFF);
    send_action(ACT_SPARE, 8'h00);
  endtask

  // One byte of each escape class plus the range edges
  task automatic test_escape_table();
    logic [7:0] bytes_list [] = '{8'h22, 8'h5C, 8'h2F, 8'h08, 8'h0C, 8'h0A,
                                  8'h0D, 8'h09, 8'h00, 8'h0B, 8'h1F, 8'h20,
                                  8'h41, 8'h7E, 8'h7F, 8'h80, 8'hAA, 8'hFF};
    foreach (bytes_list[i]) send_action(ACT_CHAR, bytes_list[i]);
  endtask

  // Mostly well-formed strings, some loose items of any action
  task automatic test_random_strings(input int unsigned n_items,
                                     input int unsigned s_pct,
                                     input int unsigned r_pct);
    int unsigned sent;
    int unsigned len;
    logic [1:0]  act;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(12);
        send_action(ACT_OPEN, 8'($urandom_range(255)));
        repeat (len) send_action(ACT_CHAR, pick_char());
        send_action(ACT_CLOSE, 8'($urandom_range(255)));
        sent += len + 2;
      end else begin
        act = 2'($urandom_range(3));
        send_action(act, 8'($urandom_range(255)));
        if (act != ACT_SPARE) sent++;
      end
    end
  endtask

  // Random output backpressure
  always @(posedge clk_i) begin
    out_ready_i <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each output item with the oldest expected byte
  always @(posedge clk_i) begin : check_output
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (escaped_bytes_q.size() == 0) begin
        $error("unexpected output item: char_out %h run_last %b",
               out_item_o.char_out, out_item_o.run_last);
        error_count++;
      end else begin
        exp_item = escaped_bytes_q.pop_front();
        if (out_item_o.char_out !== exp_item.char_out) begin
          $error("char_out: expected %h, got %h", exp_item.char_out,
                 out_item_o.char_out);
          error_count++;
        end
        if (out_item_o.run_last !== exp_item.run_last) begin
          $error("run_last: expected %b, got %b", exp_item.run_last,
                 out_item_o.run_last);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 46;
    test_string_framing();
    test_escape_table();
    test_random_strings(PHASE_ITEMS, 30, 46);
    test_random_strings(PHASE_ITEMS, 46, 30);
    test_random_strings(PHASE_ITEMS, 0, 0);
    in_valid_i <= 1'b0;
    while (escaped_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/jse_pkg.sv
hw/rtl/jse_front.sv
hw/rtl/jse_cmd_queue.sv
hw/rtl/jse_back.sv
hw/rtl/json_string_escaper.sv
tb/sv/testbench.sv
